@@ sv/fmp_pkg.sv @@
// shared types and constants for the fibonacci mod m / pisano period core
// no dependencies; imported by every module of the block
package fmp_pkg;

    localparam int MOD_BITS     = 16;
    localparam int INDEX_BITS   = 63;
    localparam int PERIOD_BITS  = 19;
    localparam int DIV_CNT_BITS = $clog2(INDEX_BITS + 1);

    typedef logic [MOD_BITS-1:0]     mod_t;
    typedef logic [INDEX_BITS-1:0]   index_t;
    typedef logic [PERIOD_BITS-1:0]  period_t;
    typedef logic [DIV_CNT_BITS-1:0] div_cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_DIVIDE,
        ST_ITER
    } state_t;

    // commands to the residue pair unit
    typedef struct packed {
        logic load;
        logic step;
    } pair_cmd_t;

    // status of the residue pair unit
    typedef struct packed {
        mod_t cur;
        mod_t sum;
    } pair_stat_t;

    // commands to the serial remainder unit
    typedef struct packed {
        logic load;
        logic step;
    } div_cmd_t;

    // status of the serial remainder unit
    typedef struct packed {
        logic    finished;
        period_t rem;
    } div_stat_t;

endpackage

@@ sv/fmp_pair_unit.sv @@
// residue pair (prev, cur) of the fibonacci sequence mod m with one modular adder
// depends on fmp_pkg
module fmp_pair_unit
    import fmp_pkg::*;
(
    input  logic       clk,
    input  mod_t       modulus,
    input  pair_cmd_t  cmd,
    output pair_stat_t stat
);

    mod_t                prev_reg;
    mod_t                prev_next;
    mod_t                cur_reg;
    mod_t                cur_next;
    logic [MOD_BITS:0]   raw_sum;
    mod_t                sum_mod;

    // add then conditional subtract of m
    always_comb
    begin
        raw_sum = {1'b0, prev_reg} + {1'b0, cur_reg};
        if (raw_sum >= {1'b0, modulus})
        begin
            raw_sum = raw_sum - {1'b0, modulus};
        end
        sum_mod = raw_sum[MOD_BITS-1:0];
    end

    // pair update
    always_comb
    begin
        prev_next = prev_reg;
        cur_next  = cur_reg;
        if (cmd.load)
        begin
            prev_next = '0;
            cur_next  = mod_t'(1);
        end
        else if (cmd.step)
        begin
            prev_next = cur_reg;
            cur_next  = sum_mod;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
    end

    assign stat.cur = cur_reg;
    assign stat.sum = sum_mod;

endmodule

@@ sv/fmp_rem_unit.sv @@
// restoring serial remainder: index mod period, one index bit per cycle while step is held
// depends on fmp_pkg
module fmp_rem_unit
    import fmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  index_t    dividend,
    input  period_t   divisor,
    input  div_cmd_t  cmd,
    output div_stat_t stat
);

    index_t                 shift_reg;
    index_t                 shift_next;
    period_t                rem_reg;
    period_t                rem_next;
    div_cnt_t               cnt_reg;
    div_cnt_t               cnt_next;
    logic [PERIOD_BITS:0]   trial;

    // shift in the next index bit, subtract the divisor when it fits
    always_comb
    begin
        trial = {rem_reg, shift_reg[INDEX_BITS-1]};
        if (trial >= {1'b0, divisor})
        begin
            trial = trial - {1'b0, divisor};
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        if (cmd.load)
        begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = div_cnt_t'(INDEX_BITS);
        end
        else if (cmd.step && (cnt_reg != '0))
        begin
            shift_next = {shift_reg[INDEX_BITS-2:0], 1'b0};
            rem_next   = trial[PERIOD_BITS-1:0];
            cnt_next   = cnt_reg - div_cnt_t'(1);
        end
    end

    // bit counter is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign stat.finished = (cnt_reg == '0);
    assign stat.rem      = rem_reg;

endmodule

@@ sv/fibonacci_mod_pisano_core.sv @@
// F(n) mod m via the pisano period: sequencer with a shared modular adder
// for m of 0 or 1 no search is made; otherwise P, the pisano period (at most 6m), is found,
// then k = n mod P, then F(k) when k >= 2; P and F(k) are stepped on the one modular adder and
// the remainder takes one index bit per cycle; busy stays high for a whole request with m >= 2
// throughput: one request at a time, the next is taken in the cycle done is shown
// reset: asynchronous active-low, returns to idle with busy and done low
module fibonacci_mod_pisano_core
    import fmp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  index_t  n_index,
    input  mod_t    modulus,
    output logic    done,
    output mod_t    fib_mod,
    output period_t period,
    output logic    bad_modulus
);

    state_t     state_reg;
    state_t     state_next;
    mod_t       m_reg;
    mod_t       m_next;
    period_t    steps_reg;
    period_t    steps_next;
    period_t    iter_cnt_reg;
    period_t    iter_cnt_next;
    period_t    period_reg;
    period_t    period_next;
    mod_t       fib_reg;
    mod_t       fib_next;
    logic       bad_reg;
    logic       bad_next;
    logic       done_reg;
    logic       done_next;
    pair_cmd_t  pair_cmd;
    pair_stat_t pair_stat;
    div_cmd_t   div_cmd;
    div_stat_t  div_stat;

    fmp_pair_unit u_pair (
        .clk     (clk),
        .modulus (m_reg),
        .cmd     (pair_cmd),
        .stat    (pair_stat)
    );

    fmp_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .dividend (n_index),
        .divisor  (period_reg),
        .cmd      (div_cmd),
        .stat     (div_stat)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        m_next        = m_reg;
        steps_next    = steps_reg;
        iter_cnt_next = iter_cnt_reg;
        period_next   = period_reg;
        fib_next      = fib_reg;
        bad_next      = bad_reg;
        done_next     = 1'b0;
        pair_cmd      = '0;
        div_cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    m_next = modulus;
                    if (modulus == '0)
                    begin
                        fib_next    = '0;
                        period_next = '0;
                        bad_next    = 1'b1;
                        done_next   = 1'b1;
                    end
                    else if (modulus == mod_t'(1))
                    begin
                        fib_next    = '0;
                        period_next = period_t'(1);
                        bad_next    = 1'b0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        bad_next      = 1'b0;
                        steps_next    = '0;
                        pair_cmd.load = 1'b1;
                        div_cmd.load  = 1'b1;
                        state_next    = ST_PERIOD;
                    end
                end
            end
            ST_PERIOD:
            begin
                // step until the pair 0,1 comes back
                pair_cmd.step = 1'b1;
                steps_next    = steps_reg + period_t'(1);
                if ((pair_stat.cur == '0) && (pair_stat.sum == mod_t'(1)))
                begin
                    period_next = steps_reg + period_t'(1);
                    state_next  = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_stat.finished)
                begin
                    if (div_stat.rem < period_t'(2))
                    begin
                        fib_next   = mod_t'(div_stat.rem[0]);
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pair_cmd.load = 1'b1;
                        iter_cnt_next = div_stat.rem - period_t'(1);
                        state_next    = ST_ITER;
                    end
                end
                else
                begin
                    div_cmd.step = 1'b1;
                end
            end
            ST_ITER:
            begin
                // k-1 steps from the pair 0,1
                if (iter_cnt_reg == '0)
                begin
                    fib_next   = pair_stat.cur;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    pair_cmd.step = 1'b1;
                    iter_cnt_next = iter_cnt_reg - period_t'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        m_reg        <= m_next;
        steps_reg    <= steps_next;
        iter_cnt_reg <= iter_cnt_next;
        period_reg   <= period_next;
        fib_reg      <= fib_next;
        bad_reg      <= bad_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign fib_mod     = fib_reg;
    assign period      = period_reg;
    assign bad_modulus = bad_reg;

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for fibonacci_mod_pisano_core: F(n) mod m and the pisano period
// depends on fmp_pkg and the core; requests are predicted once busy is seen low, replies checked in order
module tb_top;
    import fmp_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 4000000;
    localparam int          RANDOM_COUNT = 80;
    localparam int          TAIL_CYCLES  = 20;

    // one predicted reply of the core
    typedef struct {
        mod_t    fib;
        period_t period;
        logic    bad;
    } fib_reply_t;

    // predicts each accepted request and matches replies in arrival order
    class fib_mod_board;
        fib_reply_t pending_replies[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        // sum of two residues below m, with one conditional subtract
        static function mod_t residue_add(mod_t a, mod_t b, mod_t m);
            logic [MOD_BITS:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            if (sum >= {1'b0, m})
                sum = sum - {1'b0, m};
            return sum[MOD_BITS-1:0];
        endfunction

        static function fib_reply_t fib_mod_of(index_t n, mod_t m);
            fib_reply_t       r;
            mod_t             lo;
            mod_t             hi;
            mod_t             nxt;
            longint unsigned  pis;
            longint unsigned  k;
            r.fib    = '0;
            r.period = '0;
            r.bad    = 1'b0;
            if (m == '0)
            begin
                r.bad = 1'b1;
            end
            else if (m == mod_t'(1))
            begin
                r.period = period_t'(1);
            end
            else
            begin
                // step the sequence until the pair 0,1 comes round again
                lo  = '0;
                hi  = mod_t'(1);
                pis = '0;
                do
                begin
                    nxt = residue_add(lo, hi, m);
                    lo  = hi;
                    hi  = nxt;
                    pis++;
                end
                while (!(lo == '0 && hi == mod_t'(1)));
                r.period = period_t'(pis);
                // walk up to the reduced index
                k = {1'b0, n} % pis;
                if (k < 2)
                begin
                    r.fib = mod_t'(k);
                end
                else
                begin
                    lo = '0;
                    hi = mod_t'(1);
                    for (longint unsigned i = 2; i <= k; i++)
                    begin
                        nxt = residue_add(lo, hi, m);
                        lo  = hi;
                        hi  = nxt;
                    end
                    r.fib = hi;
                end
            end
            return r;
        endfunction

        function void note_request(index_t n, mod_t m);
            pending_replies.push_back(fib_mod_of(n, m));
        endfunction

        function void check_reply(mod_t fib, period_t pis, logic bad);
            fib_reply_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply with no request outstanding: fib %0d period %0d bad %0b",
                         $time, fib, pis, bad);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (fib !== want.fib)
            begin
                $display("%0t: fib_mod expected %0d actual %0d", $time, want.fib, fib);
                errors++;
            end
            if (pis !== want.period)
            begin
                $display("%0t: period expected %0d actual %0d", $time, want.period, pis);
                errors++;
            end
            if (bad !== want.bad)
            begin
                $display("%0t: bad_modulus expected %0b actual %0b", $time, want.bad, bad);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    index_t  n_index = '0;
    mod_t    modulus = '0;
    logic    done;
    mod_t    fib_mod;
    period_t period;
    logic    bad_modulus;

    fib_mod_board board = new();
    int unsigned  idle_cycles = 0;
    bit           gaps_on = 1'b1;

    fibonacci_mod_pisano_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .n_index     (n_index),
        .modulus     (modulus),
        .done        (done),
        .fib_mod     (fib_mod),
        .period      (period),
        .bad_modulus (bad_modulus)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // reply checking
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_reply(fib_mod, period, bad_modulus);
    end

    // watchdog on stretches with neither a request nor a reply
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // issue one request after an optional gap; returns once it has been taken
    task automatic send_request(index_t n, mod_t m);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        n_index <= n;
        modulus <= m;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        board.note_request(n, m);
    endtask

    function automatic index_t wide_index();
        return index_t'({$urandom, $urandom});
    endfunction

    initial
    begin
        int   pick;
        index_t n;
        mod_t   m;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero modulus, modulus one, small index, extremes
        send_request(index_t'(5), mod_t'(0));
        send_request('1, mod_t'(0));
        send_request('0, mod_t'(1));
        send_request('1, mod_t'(1));
        send_request('0, mod_t'(2));
        send_request(index_t'(1), mod_t'(2));
        send_request('0, mod_t'(10));
        send_request(index_t'(1), mod_t'(10));
        // index a multiple of the period, and one past it
        send_request(index_t'(60), mod_t'(10));
        send_request(index_t'(61), mod_t'(10));
        send_request(index_t'(2), mod_t'(3));
        send_request('1, mod_t'(2));
        send_request('1, mod_t'(65535));
        send_request('0, mod_t'(65535));
        send_request(index_t'(1) << (INDEX_BITS - 1), mod_t'(65534));
        send_request(wide_index(), mod_t'(32768));
        send_request(wide_index(), mod_t'(16'h5555));
        send_request(wide_index(), mod_t'(16'h2aaa));
        // period of 6m, and the longest walk to the reduced index
        send_request(index_t'(187499), mod_t'(31250));
        send_request(index_t'(100), mod_t'(1000));

        // random: mostly small moduli so the period search stays short
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i % 16 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                m = mod_t'($urandom_range(0, 1));
            else if (pick < 88)
                m = mod_t'($urandom_range(2, 255));
            else
                m = mod_t'($urandom_range(256, 2047));
            if ($urandom_range(0, 1) == 0)
                n = index_t'($urandom_range(0, 4 * m + 3));
            else
                n = wide_index();
            send_request(n, m);
        end
        start <= 1'b0;

        // drain outstanding replies, then allow a short tail for strays
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
sv/fmp_pkg.sv
sv/fmp_pair_unit.sv
sv/fmp_rem_unit.sv
sv/fibonacci_mod_pisano_core.sv
bench/tb_top.sv
